/* hdl/fsp_pkg.sv */
// Shared types, widths and coefficient tables for the Fibonacci sphere point generator.
`timescale 1ns / 1ps
package fsp_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_POINTS = 65536;
   localparam int DEF_FRAC_BITS  = 15;

   // Widths sized for the largest parameter values
   localparam int FB_MAX  = 30;
   localparam int PW_MAX  = 21;
   localparam int NUM_W   = PW_MAX + FB_MAX + 1;
   localparam int ZW      = FB_MAX + 1;
   localparam int SV_W    = 2 * FB_MAX + 2;
   localparam int SREM_W  = FB_MAX + 4;

   // Taylor series cells, one cosine coefficient each and one sine coefficient in every cell but the first
   localparam int TRIG_CELLS = 7;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // Word handed from cell to cell
   typedef struct packed {
      logic              oor;
      logic              zneg;
      logic [PW_MAX-1:0] n;
      logic [NUM_W-1:0]  num;
      logic [PW_MAX-1:0] rem;
      logic [ZW-1:0]     quo;
      logic [SV_W-1:0]   sv;
      logic [SREM_W-1:0] srem;
      logic [ZW-1:0]     root;
      logic [ZW-1:0]     rad;
      logic [31:0]       ang;
      logic [1:0]        quad;
      logic              tneg;
      logic [29:0]       th;
      logic [29:0]       t;
      logic [30:0]       s;
      logic [30:0]       c;
      logic [29:0]       ps;
      logic [29:0]       pc;
      logic [29:0]       es;
      logic [29:0]       ec;
   } token_type;

   // Cosine divisor of cell k
   function automatic logic [7:0] cos_div_of(input int k);
      logic [7:0] d;
      case (k)
         0:       d = 8'd182;
         1:       d = 8'd132;
         2:       d = 8'd90;
         3:       d = 8'd56;
         4:       d = 8'd30;
         5:       d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // Sine divisor of cell k; the first cell has no sine term
   function automatic logic [7:0] sin_div_of(input int k);
      logic [7:0] d;
      case (k)
         1:       d = 8'd156;
         2:       d = 8'd110;
         3:       d = 8'd72;
         4:       d = 8'd42;
         5:       d = 8'd20;
         6:       d = 8'd6;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

endpackage

/* hdl/fsp_req_if.sv */
// Request channel carrying the point index word.
`timescale 1ns / 1ps
interface fsp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] point_index;

   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);
endinterface

/* hdl/fsp_rsp_if.sv */
// Response channel carrying one sphere point word.
`timescale 1ns / 1ps
interface fsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;
   logic               index_out_of_range;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   output index_out_of_range, input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                   input index_out_of_range, output ready);
endinterface

/* hdl/fsp_div_cell.sv */
// One restoring division cell: one quotient bit of |N-2i-1|*2^F/N.
`timescale 1ns / 1ps
module fsp_div_cell #(
   parameter int BIT_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  fsp_pkg::token_type up_tok,
   output logic               dn_valid,
   output fsp_pkg::token_type dn_tok
);
   import fsp_pkg::*;

   logic [PW_MAX:0] trial;
   logic [PW_MAX:0] diff;
   logic            ge;
   token_type       tok_in;
   token_type       tok_ff;
   logic            valid_ff;

   // Shift in the next numerator bit and try a subtract
   always_comb begin
      trial = {up_tok.rem, up_tok.num[BIT_IDX]};
      diff  = trial - {1'b0, up_tok.n};
      ge    = (trial >= {1'b0, up_tok.n});
      tok_in      = up_tok;
      tok_in.rem  = ge ? diff[PW_MAX-1:0] : trial[PW_MAX-1:0];
      tok_in.quo  = {up_tok.quo[ZW-2:0], ge};
   end

   // Advance with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_tok   = tok_ff;
endmodule

/* hdl/fsp_sqrt_cell.sv */
// One digit-by-digit square root cell: one root bit from one bit pair.
`timescale 1ns / 1ps
module fsp_sqrt_cell #(
   parameter int PAIR_LO = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  fsp_pkg::token_type up_tok,
   output logic               dn_valid,
   output fsp_pkg::token_type dn_tok
);
   import fsp_pkg::*;

   logic [SREM_W-1:0] trial;
   logic [SREM_W-1:0] test;
   logic              ge;
   token_type         tok_in;
   token_type         tok_ff;
   logic              valid_ff;

   // Bring down a bit pair and compare against 4*root+1
   always_comb begin
      trial = {up_tok.srem[SREM_W-3:0], up_tok.sv[PAIR_LO+1 -: 2]};
      test  = SREM_W'({up_tok.root, 2'b01});
      ge    = (trial >= test);
      tok_in      = up_tok;
      tok_in.srem = ge ? (trial - test) : trial;
      tok_in.root = {up_tok.root[ZW-2:0], ge};
   end

   // Advance with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_tok   = tok_ff;
endmodule

/* hdl/fsp_trig_cell.sv */
// One Horner step of the sine and cosine series: multiply, divide by a constant, subtract.
`timescale 1ns / 1ps
module fsp_trig_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               up_valid,
   input  fsp_pkg::token_type up_tok,
   output logic               dn_valid,
   output fsp_pkg::token_type dn_tok
);
   import fsp_pkg::*;

   localparam logic [7:0]  DivC    = cos_div_of(CELL_IDX);
   localparam logic [7:0]  DivS    = sin_div_of(CELL_IDX);
   localparam logic [33:0] RECIP_C = 34'((64'd1 << 33) / DivC);
   localparam logic [33:0] RECIP_S = 34'((64'd1 << 33) / DivS);
   localparam bit          SIN_ON  = (CELL_IDX > 0);

   logic [60:0] prod_s;
   logic [60:0] prod_c;
   logic [63:0] est_s;
   logic [63:0] est_c;
   logic [37:0] res_s;
   logic [37:0] res_c;
   logic [29:0] quo_s;
   logic [29:0] quo_c;
   token_type   a_in, b_in, c_in;
   token_type   a_ff, b_ff, c_ff;
   logic [2:0]  valid_ff;

   // Step one: t times the running sums
   always_comb begin
      prod_s  = 61'(up_tok.t) * 61'(up_tok.s);
      prod_c  = 61'(up_tok.t) * 61'(up_tok.c);
      a_in    = up_tok;
      a_in.ps = prod_s[59:30];
      a_in.pc = prod_c[59:30];
   end

   // Step two: estimate the quotient by reciprocal, low by at most one
   always_comb begin
      est_s   = 64'(a_ff.ps) * 64'(RECIP_S);
      est_c   = 64'(a_ff.pc) * 64'(RECIP_C);
      b_in    = a_ff;
      b_in.es = est_s[62:33];
      b_in.ec = est_c[62:33];
   end

   // Step three: correct the quotient and subtract from one
   always_comb begin
      res_s = 38'(b_ff.ps) - 38'(b_ff.es) * 38'(DivS);
      res_c = 38'(b_ff.pc) - 38'(b_ff.ec) * 38'(DivC);
      quo_s = b_ff.es + 30'(res_s >= 38'(DivS));
      quo_c = b_ff.ec + 30'(res_c >= 38'(DivC));
      c_in   = b_ff;
      c_in.c = ONE_Q30 - 31'(quo_c);
      c_in.s = SIN_ON ? (ONE_Q30 - 31'(quo_s)) : b_ff.s;
   end

   // Advance all three steps together
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 3'b000;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], up_valid};
      end
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign dn_valid = valid_ff[2];
   assign dn_tok   = c_ff;
endmodule

/* hdl/fibonacci_sphere_point_generator_core.sv */
// Top level: Fibonacci sphere point pipeline built from division, root and series cells.
//
//   channel  dir  width  content
//   req_ch   in   16     point_index
//   rsp_ch   out  49     coord_x, coord_y, coord_z, index_out_of_range
//   csr      in   17     point_count (write only, reset 162)
//
// One word enters per cycle and one leaves per cycle once the pipeline is full and not stalled.
// The pipeline holds FRAC_BITS+1 division cells, FRAC_BITS+1
// root cells, seven three-step series cells and seven single stages.
// Reset is synchronous and clears every valid bit; point_count returns to 162.
// A response word not taken freezes the whole pipeline; req_ch.ready is low then.
`timescale 1ns / 1ps
module fibonacci_sphere_point_generator_core #(
   parameter int MAX_POINTS = fsp_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = fsp_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   fsp_req_if.sink     req_ch,
   fsp_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);
   import fsp_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int NDIV  = F + 1;
   localparam int NSQ   = F + 1;
   localparam logic [31:0] GOLDEN_Q32  = 32'h61C8_8647;
   localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
   localparam logic [31:0] Q_ONE       = 32'd1 << F;
   localparam logic [31:0] Q_MAX       = Q_ONE - 32'd1;
   localparam logic [1:0]  QUAD_0 = 2'd0;
   localparam logic [1:0]  QUAD_1 = 2'd1;
   localparam logic [1:0]  QUAD_2 = 2'd2;

   // Saturate and sign a component, keep 16 bits
   function automatic logic [15:0] pack(input logic neg, input logic [31:0] mag);
      logic [31:0] m;
      logic [31:0] r;
      m = mag;
      if (!neg && m > Q_MAX) m = Q_MAX;
      if (neg && m > Q_ONE) m = Q_ONE;
      r = neg ? (32'd0 - m) : m;
      return r[15:0];
   endfunction

   logic        advance;
   logic [16:0] point_count_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 17'd162;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // Stage zero: clamp N, range check, numerator and azimuth
   logic [PW_MAX-1:0] n_eff;
   logic [PW_MAX-1:0] twice;
   logic [PW_MAX-1:0] mdiff;
   logic [NUM_W-1:0]  num;
   logic [47:0]       ang_full;
   token_type         s0_in, s0_ff;
   logic              s0_valid_ff;

   always_comb begin
      n_eff = (PW_MAX'(point_count_ff) > PW_MAX'(MAX_POINTS)) ?
              PW_MAX'(MAX_POINTS) : PW_MAX'(point_count_ff);
      twice    = PW_MAX'({req_ch.point_index, 1'b1});
      mdiff    = (twice > n_eff) ? (twice - n_eff) : (n_eff - twice);
      num      = (NUM_W'(mdiff) << F) + NUM_W'(n_eff >> 1);
      ang_full = 48'(req_ch.point_index) * 48'(GOLDEN_Q32);
      s0_in      = '0;
      s0_in.oor  = (PW_MAX'(req_ch.point_index) >= n_eff);
      s0_in.zneg = (twice > n_eff);
      s0_in.n    = n_eff;
      s0_in.num  = num;
      s0_in.rem  = PW_MAX'(num >> (F + 1));
      s0_in.ang  = ang_full[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_ch.valid;
      end
      if (advance) begin
         s0_ff <= s0_in;
      end
   end

   // Division chain: one quotient bit per cell
   token_type div_tok [0:NDIV];
   logic      div_valid [0:NDIV];
   assign div_tok[0]   = s0_ff;
   assign div_valid[0] = s0_valid_ff;

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      fsp_div_cell #(.BIT_IDX(F - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (div_valid[k]),
         .up_tok   (div_tok[k]),
         .dn_valid (div_valid[k+1]),
         .dn_tok   (div_tok[k+1])
      );
   end

   // Radicand 1 - z^2
   logic [2*ZW-1:0] zsq;
   token_type       sq_in, sq_ff;
   logic            sq_valid_ff;

   always_comb begin
      zsq  = (2*ZW)'(div_tok[NDIV].quo) * (2*ZW)'(div_tok[NDIV].quo);
      sq_in      = div_tok[NDIV];
      sq_in.sv   = (SV_W'(1) << (2 * F)) - SV_W'(zsq);
      sq_in.srem = '0;
      sq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= div_valid[NDIV];
      end
      if (advance) begin
         sq_ff <= sq_in;
      end
   end

   // Root chain: one root bit per cell
   token_type rt_tok [0:NSQ];
   logic      rt_valid [0:NSQ];
   assign rt_tok[0]   = sq_ff;
   assign rt_valid[0] = sq_valid_ff;

   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      fsp_sqrt_cell #(.PAIR_LO(2 * F - 2 * j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (rt_valid[j]),
         .up_tok   (rt_tok[j]),
         .dn_valid (rt_valid[j+1]),
         .dn_tok   (rt_tok[j+1])
      );
   end

   // Round the root; fold the azimuth into a quarter turn and convert to radians
   logic [31:0] ang_q;
   logic [31:0] resid;
   logic [31:0] rmag;
   logic [64:0] th_full;
   token_type   t0_in, t0_ff;
   logic        t0_valid_ff;

   always_comb begin
      ang_q   = (rt_tok[NSQ].ang + 32'h2000_0000) >> 30;
      resid   = rt_tok[NSQ].ang - (ang_q << 30);
      rmag    = resid[31] ? (32'd0 - resid) : resid;
      th_full = 65'(rmag) * 65'(HALF_PI_Q32);
      t0_in      = rt_tok[NSQ];
      t0_in.rad  = rt_tok[NSQ].root +
                   ZW'(rt_tok[NSQ].srem > SREM_W'(rt_tok[NSQ].root));
      t0_in.quad = ang_q[1:0];
      t0_in.tneg = resid[31];
      t0_in.th   = th_full[61:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else if (advance) begin
         t0_valid_ff <= rt_valid[NSQ];
      end
      if (advance) begin
         t0_ff <= t0_in;
      end
   end

   // Square of the angle, series seeds at one
   logic [59:0] tsq;
   token_type   t1_in, t1_ff;
   logic        t1_valid_ff;

   always_comb begin
      tsq     = 60'(t0_ff.th) * 60'(t0_ff.th);
      t1_in   = t0_ff;
      t1_in.t = tsq[59:30];
      t1_in.s = ONE_Q30;
      t1_in.c = ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (advance) begin
         t1_valid_ff <= t0_valid_ff;
      end
      if (advance) begin
         t1_ff <= t1_in;
      end
   end

   // Series chain
   token_type tr_tok [0:TRIG_CELLS];
   logic      tr_valid [0:TRIG_CELLS];
   assign tr_tok[0]   = t1_ff;
   assign tr_valid[0] = t1_valid_ff;

   for (genvar k = 0; k < TRIG_CELLS; k++) begin : g_trig
      fsp_trig_cell #(.CELL_IDX(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (tr_valid[k]),
         .up_tok   (tr_tok[k]),
         .dn_valid (tr_valid[k+1]),
         .dn_tok   (tr_tok[k+1])
      );
   end

   // Finish the sine and apply the quadrant
   logic [60:0]        sv_full;
   logic signed [31:0] sv_s;
   logic signed [31:0] cv_s;
   logic signed [31:0] co_in, si_in, co_ff, si_ff;
   token_type          e0_ff;
   logic               e0_valid_ff;

   always_comb begin
      sv_full = 61'(tr_tok[TRIG_CELLS].th) * 61'(tr_tok[TRIG_CELLS].s);
      sv_s    = signed'(32'(sv_full[59:30]));
      if (tr_tok[TRIG_CELLS].tneg) sv_s = -sv_s;
      cv_s    = signed'(32'(tr_tok[TRIG_CELLS].c));
      case (tr_tok[TRIG_CELLS].quad)
         QUAD_0:  begin co_in = cv_s;  si_in = sv_s;  end
         QUAD_1:  begin co_in = -sv_s; si_in = cv_s;  end
         QUAD_2:  begin co_in = -cv_s; si_in = -sv_s; end
         default: begin co_in = sv_s;  si_in = -cv_s; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff <= 1'b0;
      end else if (advance) begin
         e0_valid_ff <= tr_valid[TRIG_CELLS];
      end
      if (advance) begin
         e0_ff <= tr_tok[TRIG_CELLS];
         co_ff <= co_in;
         si_ff <= si_in;
      end
   end

   // Scale cos and sin by the radius
   logic [31:0] cmag, smag;
   logic [61:0] px_in, py_in, px_ff, py_ff;
   logic        nx_ff, ny_ff;
   token_type   e1_ff;
   logic        e1_valid_ff;

   always_comb begin
      cmag  = co_ff[31] ? (32'd0 - 32'(co_ff)) : 32'(co_ff);
      smag  = si_ff[31] ? (32'd0 - 32'(si_ff)) : 32'(si_ff);
      px_in = 62'(e0_ff.rad) * 62'(cmag);
      py_in = 62'(e0_ff.rad) * 62'(smag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (advance) begin
         e1_valid_ff <= e0_valid_ff;
      end
      if (advance) begin
         e1_ff <= e0_ff;
         px_ff <= px_in;
         py_ff <= py_in;
         nx_ff <= co_ff[31];
         ny_ff <= si_ff[31];
      end
   end

   // Round, saturate and register the response word
   logic [61:0] rx, ry;
   logic [31:0] mx, my;
   logic [15:0] x_in, y_in, z_in;
   logic [15:0] x_ff, y_ff, z_ff;
   logic        oor_ff;
   logic        e2_valid_ff;

   always_comb begin
      rx = px_ff + 62'h2000_0000;
      ry = py_ff + 62'h2000_0000;
      mx = rx[61:30];
      my = ry[61:30];
      x_in = pack(nx_ff && (mx != 32'd0), mx);
      y_in = pack(ny_ff && (my != 32'd0), my);
      z_in = pack(e1_ff.zneg && (e1_ff.quo != '0), 32'(e1_ff.quo));
      if (e1_ff.oor) begin
         x_in = 16'd0;
         y_in = 16'd0;
         z_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (advance) begin
         e2_valid_ff <= e1_valid_ff;
      end
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         oor_ff <= e1_ff.oor;
      end
   end

   // Hold everything while the response word waits
   assign advance      = !e2_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign rsp_ch.valid              = e2_valid_ff;
   assign rsp_ch.coord_x            = signed'(x_ff);
   assign rsp_ch.coord_y            = signed'(y_ff);
   assign rsp_ch.coord_z            = signed'(z_ff);
   assign rsp_ch.index_out_of_range = oor_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.index_out_of_range |->
         rsp_ch.coord_x == 16'sd0 && rsp_ch.coord_y == 16'sd0 && rsp_ch.coord_z == 16'sd0)
      else $error("out-of-range word carries a nonzero vector");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("request ready does not follow pipeline advance");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s0_valid_ff) && $stable(e1_valid_ff))
      else $error("pipeline moved during a stall");
endmodule

/* tb/sv/fibonacci_sphere_point_generator_core_tb.sv */
// Testbench for the Fibonacci sphere point generator core: self-checking, random and directed.
`timescale 1ns / 1ps
module fibonacci_sphere_point_generator_core_tb;
   import fsp_pkg::*;

   localparam int LATENCY    = 2 * DEF_FRAC_BITS + 30;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               oor;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   fsp_req_if req_ch ();
   fsp_rsp_if rsp_ch ();

   fibonacci_sphere_point_generator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch.sink),
      .rsp_ch     (rsp_ch.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   logic [16:0] count_shadow = 17'd162;
   point_type   point_queue[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          stall_en = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Integer square root rounded to nearest
   function automatic longint unsigned root_nearest(input longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      if (v > res) res++;
      return res;
   endfunction

   // Cosine and sine of an angle in 2^-32 turns, Q30
   task automatic turn_trig(input logic [31:0] a, output longint co, output longint si);
      longint unsigned sdiv[6], cdiv[7];
      logic [31:0]     q, u;
      bit              neg;
      longint unsigned m, th, t, s, c;
      longint          sv, cv;
      sdiv = '{156, 110, 72, 42, 20, 6};
      cdiv = '{182, 132, 90, 56, 30, 12, 2};
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      u = a - (q << 30);
      neg = u[31];
      m = neg ? 64'(32'(0 - u)) : 64'(u);
      th = (m * 64'd6746518852) >> 32;
      t = (th * th) >> 30;
      s = 64'd1 << 30;
      c = 64'd1 << 30;
      for (int k = 0; k < 6; k++) s = (64'd1 << 30) - ((t * s) >> 30) / sdiv[k];
      for (int k = 0; k < 7; k++) c = (64'd1 << 30) - ((t * c) >> 30) / cdiv[k];
      sv = longint'((th * s) >> 30);
      cv = longint'(c);
      if (neg) sv = -sv;
      case (q)
         0: begin co = cv;  si = sv;  end
         1: begin co = -sv; si = cv;  end
         2: begin co = -cv; si = -sv; end
         default: begin co = sv; si = -cv; end
      endcase
   endtask

   // Saturate a sign and magnitude into Q1.15
   function automatic logic [15:0] pack_q15(input bit neg, input longint unsigned mag);
      if (!neg && mag > 32767) mag = 32767;
      if (neg && mag > 32768) mag = 32768;
      return neg ? 16'(-mag) : 16'(mag);
   endfunction

   function automatic logic [15:0] scale_radius(input longint unsigned rad, input longint trig);
      bit              neg;
      longint unsigned tm, mag;
      neg = trig < 0;
      tm = neg ? longint'(-trig) : trig;
      mag = (rad * tm + (64'd1 << 29)) >> 30;
      return pack_q15(neg && mag != 0, mag);
   endfunction

   // Expected sphere point for one index
   task automatic predict_point(input logic [15:0] idx, output point_type p);
      longint unsigned n, i, twice, m, zmag, rad;
      bit              zneg;
      longint          co, si;
      n = count_shadow;
      i = idx;
      if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
      p = '0;
      if (i >= n) begin
         p.oor = 1'b1;
         return;
      end
      twice = 2 * i + 1;
      zneg = twice > n;
      m = zneg ? twice - n : n - twice;
      zmag = (m * 32768 + n / 2) / n;
      rad = root_nearest((64'd1 << 30) - zmag * zmag);
      turn_trig(32'(i * 64'h61C88647), co, si);
      p.x = scale_radius(rad, co);
      p.y = scale_radius(rad, si);
      p.z = pack_q15(zneg && zmag != 0, zmag);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Receiver stall pattern
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      if (!stall_en) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 15) < 11);
   end

   // Check each accepted result word
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (point_queue.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = point_queue.pop_front();
            if (rsp_ch.coord_x !== want.x) report_mismatch("coord_x", rsp_ch.coord_x, want.x);
            if (rsp_ch.coord_y !== want.y) report_mismatch("coord_y", rsp_ch.coord_y, want.y);
            if (rsp_ch.coord_z !== want.z) report_mismatch("coord_z", rsp_ch.coord_z, want.z);
            if (rsp_ch.index_out_of_range !== want.oor)
               report_mismatch("index_out_of_range", rsp_ch.index_out_of_range, want.oor);
         end
      end
   end

   // Watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Send one index word; valid stays high when back to back
   task automatic send_index(input logic [15:0] idx, input bit keep);
      point_type p;
      req_ch.valid <= 1'b1;
      req_ch.point_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      predict_point(idx, p);
      point_queue.push_back(p);
      @(negedge clock);
      if (!keep) req_ch.valid <= 1'b0;
   endtask

   // Send a list in random bursts; an idle gap ends each burst
   task automatic send_burst_list(input logic [15:0] list[$]);
      int burst;
      int gap;
      burst = $urandom_range(1, 20);
      repeat ($urandom_range(0, 6)) @(negedge clock);
      foreach (list[k]) begin
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
         end else begin
            gap = 0;
         end
         send_index(list[k], gap == 0 && k != list.size() - 1);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_pipe();
      while (point_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_count(input logic [16:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      count_shadow = value;
   endtask

   // Field extremes at the reset count, including out of range
   task automatic test_directed_reset_count();
      logic [15:0] list[$];
      list = '{16'd0, 16'd1, 16'd80, 16'd81, 16'd160, 16'd161, 16'd162, 16'd163,
               16'hFFFF, 16'h8000, 16'h5555, 16'h2AAA};
      send_burst_list(list);
      drain_pipe();
   endtask

   // Count extremes: zero, one, two, maximum and above the maximum
   task automatic test_count_extremes();
      logic [16:0] counts[$];
      logic [15:0] list[$];
      counts = '{17'd0, 17'd1, 17'd2, 17'd65536, 17'h1FFFF};
      foreach (counts[c]) begin
         write_count(counts[c]);
         list = '{16'd0, 16'd1, 16'd2, 16'd32767, 16'd32768, 16'hFFFF};
         send_burst_list(list);
         drain_pipe();
      end
   endtask

   // Random indices over several counts; mostly in range
   task automatic test_random_indices();
      logic [15:0] list[$];
      logic [16:0] n;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: n = 17'd65536;
            1: n = 17'd3;
            2: n = 17'h1FFFF;
            default: n = 17'($urandom_range(1, 65536));
         endcase
         write_count(n);
         stall_en = (ph != 3);
         list.delete();
         repeat (140) begin
            if ($urandom_range(0, 9) == 0) list.push_back(16'($urandom()));
            else list.push_back(16'($urandom_range(0, (n > 65536 ? 65536 : n) - 1)));
         end
         send_burst_list(list);
         drain_pipe();
      end
      stall_en = 1'b1;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.point_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_reset_count();
      test_count_extremes();
      test_random_indices();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
